@@ rtl/chrs_pkg.sv @@
// chrs_pkg: shared types and constants for the consistent-hash replica selector
// depends on nothing; used by every module of the block
`default_nettype none

package chrs_pkg;

    // fnv-1a hash constants (prime is 2^40 + 0x1b3)
    localparam logic [63:0] FNV_BASIS    = 64'hCBF29CE484222325;
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;
    localparam int unsigned FNV_PRIME_SH = 40;

    // splitmix64 constants
    localparam logic [63:0] MIX_GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_C1     = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_C2     = 64'h94D049BB133111EB;
    localparam int unsigned MIX_SH1    = 30;
    localparam int unsigned MIX_SH2    = 27;
    localparam int unsigned MIX_SH3    = 31;

    // input function codes
    typedef enum logic [1:0] {
        FN_CLEAR = 2'd0,
        FN_ADD   = 2'd1,
        FN_BYTE  = 2'd2,
        FN_NONE  = 2'd3
    } func_t;

    // commands passed from front to back
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_LOOKUP = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [63:0] key;
        logic [63:0] data;   // ring position for add, hash for lookup
    } cmd_t;

    // multiply sequencer step of the front
    typedef enum logic [1:0] {
        MS_LL = 2'd0,
        MS_LH = 2'd1,
        MS_HL = 2'd2
    } mul_step_t;

    typedef enum logic {
        FR_IDLE = 1'b0,
        FR_MUL  = 1'b1
    } front_state_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_SCAN = 2'd1,
        BK_EMIT = 2'd2
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/chrs_front.sv @@
// chrs_front: accepts requests, folds key bytes into the fnv-1a hash and
// computes ring positions with a shared 32x32 multiplier; uses chrs_pkg
`default_nettype none

module chrs_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [1:0]   func,
    input  wire logic [63:0]  node_key,
    input  wire logic [7:0]   key_byte,
    input  wire logic         byte_valid,
    input  wire logic         last_byte,
    output logic              q_push,
    output chrs_pkg::cmd_t    q_cmd,
    input  wire logic         q_full
);

    chrs_pkg::front_state_t state_reg, state_next;
    chrs_pkg::mul_step_t    step_reg, step_next;
    logic                   second_reg, second_next;
    logic [63:0]            hash_reg, hash_next;
    logic [63:0]            x_reg, x_next;
    logic [63:0]            acc_reg, acc_next;
    logic [63:0]            key_reg, key_next;

    logic                   accept;
    logic [63:0]            hv;
    logic [63:0]            hash_step;
    logic [63:0]            pre;
    logic [63:0]            cst;
    logic [31:0]            op_a;
    logic [31:0]            op_b;
    logic [63:0]            prod;
    logic [63:0]            y;

    assign full   = (state_reg != chrs_pkg::FR_IDLE) || q_full;
    assign accept = push && !full;

    // fnv-1a step: (h ^ b) * prime as shift plus narrow multiply
    assign hv        = hash_reg ^ {56'd0, key_byte};
    assign hash_step = (hv << chrs_pkg::FNV_PRIME_SH) + (hv * 64'(chrs_pkg::FNV_PRIME_LO));

    // first mix round before the multiplies
    assign pre = node_key + chrs_pkg::MIX_GOLDEN;

    // shared multiplier operand select
    assign cst = second_reg ? chrs_pkg::MIX_C2 : chrs_pkg::MIX_C1;
    always_comb
    begin
        unique case (step_reg)
            chrs_pkg::MS_LL:
            begin
                op_a = x_reg[31:0];
                op_b = cst[31:0];
            end
            chrs_pkg::MS_LH:
            begin
                op_a = x_reg[31:0];
                op_b = cst[63:32];
            end
            default:
            begin
                op_a = x_reg[63:32];
                op_b = cst[31:0];
            end
        endcase
    end
    assign prod = 64'(op_a) * 64'(op_b);
    assign y    = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= chrs_pkg::FR_IDLE;
            step_reg   <= chrs_pkg::MS_LL;
            second_reg <= 1'b0;
            hash_reg   <= chrs_pkg::FNV_BASIS;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            second_reg <= second_next;
            hash_reg   <= hash_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        acc_reg <= acc_next;
        key_reg <= key_next;
    end

    // next state and command output
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        second_next = second_reg;
        hash_next   = hash_reg;
        x_next      = x_reg;
        acc_next    = acc_reg;
        key_next    = key_reg;
        q_push      = 1'b0;
        q_cmd.op    = chrs_pkg::OP_CLEAR;
        q_cmd.key   = key_reg;
        q_cmd.data  = hash_reg;
        unique case (state_reg)
            chrs_pkg::FR_IDLE:
            begin
                if (accept)
                begin
                    unique case (chrs_pkg::func_t'(func))
                        chrs_pkg::FN_CLEAR:
                        begin
                            q_push   = 1'b1;
                            q_cmd.op = chrs_pkg::OP_CLEAR;
                        end
                        chrs_pkg::FN_ADD:
                        begin
                            state_next  = chrs_pkg::FR_MUL;
                            step_next   = chrs_pkg::MS_LL;
                            second_next = 1'b0;
                            key_next    = node_key;
                            x_next      = pre ^ (pre >> chrs_pkg::MIX_SH1);
                        end
                        chrs_pkg::FN_BYTE:
                        begin
                            if (byte_valid)
                                hash_next = hash_step;
                            if (last_byte)
                            begin
                                q_push     = 1'b1;
                                q_cmd.op   = chrs_pkg::OP_LOOKUP;
                                q_cmd.data = hash_next;
                                hash_next  = chrs_pkg::FNV_BASIS;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                unique case (step_reg)
                    chrs_pkg::MS_LL:
                    begin
                        acc_next  = prod;
                        step_next = chrs_pkg::MS_LH;
                    end
                    chrs_pkg::MS_LH:
                    begin
                        acc_next  = y;
                        step_next = chrs_pkg::MS_HL;
                    end
                    default:
                    begin
                        if (!second_reg)
                        begin
                            step_next   = chrs_pkg::MS_LL;
                            second_next = 1'b1;
                            x_next      = y ^ (y >> chrs_pkg::MIX_SH2);
                        end
                        // hold the finished position until the queue has room
                        else if (!q_full)
                        begin
                            step_next  = chrs_pkg::MS_LL;
                            q_push     = 1'b1;
                            q_cmd.op   = chrs_pkg::OP_ADD;
                            q_cmd.data = y ^ (y >> chrs_pkg::MIX_SH3);
                            state_next = chrs_pkg::FR_IDLE;
                        end
                    end
                endcase
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/chrs_cmd_queue.sv @@
// chrs_cmd_queue: two-entry command queue between front and back
// depends on chrs_pkg for the command type
`default_nettype none

module chrs_cmd_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_en,
    input  chrs_pkg::cmd_t    wr_cmd,
    output logic              q_full,
    input  wire logic         rd_en,
    output chrs_pkg::cmd_t    rd_cmd,
    output logic              q_valid
);

    chrs_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     cnt_reg;

    assign q_full  = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign rd_cmd  = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= !wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

endmodule

`default_nettype wire

@@ rtl/chrs_back.sv @@
// chrs_back: node table, ring scan for the replica list and result register
// depends on chrs_pkg for command and state types
`default_nettype none

module chrs_back #(
    parameter int MAX_NODES = 64,
    parameter int REPLICAS  = 3
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         q_valid,
    input  chrs_pkg::cmd_t    q_cmd,
    output logic              q_pop,
    output logic              empty,
    input  wire logic         pop,
    output logic [63:0]       owner_key,
    output logic [1:0]        rank,
    output logic              table_empty,
    output logic              overflow,
    output logic              last
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int NW = $clog2(REPLICAS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_NODES);
    localparam logic [NW-1:0] REP_N   = NW'(REPLICAS);

    // node table: key in the upper half, ring position in the lower half
    logic [127:0]  mem [MAX_NODES];
    logic [127:0]  rd_reg;
    logic          rdv_reg;

    chrs_pkg::back_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          drop_reg, drop_next;
    logic [CW-1:0] addr_reg, addr_next;
    logic [63:0]   hash_reg, hash_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic [NW-1:0] cnt_out_reg, cnt_out_next;

    // sorted candidate lists: at or above the hash, and whole ring
    logic [63:0]   ab_key_reg [REPLICAS];
    logic [63:0]   ab_pos_reg [REPLICAS];
    logic [NW-1:0] ab_n_reg;
    logic [63:0]   al_key_reg [REPLICAS];
    logic [63:0]   al_pos_reg [REPLICAS];
    logic [NW-1:0] al_n_reg;

    logic          out_valid_reg, out_valid_next;
    logic [63:0]   out_key_reg, out_key_next;
    logic [1:0]    out_rank_reg, out_rank_next;
    logic          out_empty_reg, out_empty_next;
    logic          out_ovf_reg, out_ovf_next;
    logic          out_last_reg, out_last_next;

    logic          out_free;
    logic          issue;
    logic          wr_en;
    logic [63:0]   e_key;
    logic [63:0]   e_pos;
    logic          e_above;
    logic [REPLICAS-1:0] ab_lt;
    logic [REPLICAS-1:0] al_lt;
    logic [NW-1:0] sel_al;
    logic [63:0]   sel_key;

    assign out_free    = !out_valid_reg || pop;
    assign empty       = !out_valid_reg;
    assign owner_key   = out_key_reg;
    assign rank        = out_rank_reg;
    assign table_empty = out_empty_reg;
    assign overflow    = out_ovf_reg;
    assign last        = out_last_reg;

    assign issue = (state_reg == chrs_pkg::BK_SCAN) && (addr_reg != count_reg);
    assign wr_en = q_pop && (q_cmd.op == chrs_pkg::OP_ADD) && (count_reg != CNT_MAX);

    // table write and registered scan read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[AW-1:0]] <= {q_cmd.key, q_cmd.data};
        rd_reg <= mem[addr_reg[AW-1:0]];
    end

    // entry being inserted and its order against each list slot
    assign e_key   = rd_reg[127:64];
    assign e_pos   = rd_reg[63:0];
    assign e_above = (e_pos >= hash_reg);
    always_comb
    begin
        for (int j = 0; j < REPLICAS; j++)
        begin
            ab_lt[j] = (NW'(j) >= ab_n_reg) || (e_pos < ab_pos_reg[j]) ||
                       ((e_pos == ab_pos_reg[j]) && (e_key < ab_key_reg[j]));
            al_lt[j] = (NW'(j) >= al_n_reg) || (e_pos < al_pos_reg[j]) ||
                       ((e_pos == al_pos_reg[j]) && (e_key < al_key_reg[j]));
        end
    end

    // sorted insertion into both lists
    always_ff @(posedge clk)
    begin
        if (rdv_reg)
        begin
            for (int j = 0; j < REPLICAS; j++)
            begin
                if (e_above && ab_lt[j])
                begin
                    if (j == 0 || !ab_lt[(j > 0) ? j - 1 : 0])
                    begin
                        ab_key_reg[j] <= e_key;
                        ab_pos_reg[j] <= e_pos;
                    end
                    else
                    begin
                        ab_key_reg[j] <= ab_key_reg[(j > 0) ? j - 1 : 0];
                        ab_pos_reg[j] <= ab_pos_reg[(j > 0) ? j - 1 : 0];
                    end
                end
                if (al_lt[j])
                begin
                    if (j == 0 || !al_lt[(j > 0) ? j - 1 : 0])
                    begin
                        al_key_reg[j] <= e_key;
                        al_pos_reg[j] <= e_pos;
                    end
                    else
                    begin
                        al_key_reg[j] <= al_key_reg[(j > 0) ? j - 1 : 0];
                        al_pos_reg[j] <= al_pos_reg[(j > 0) ? j - 1 : 0];
                    end
                end
            end
        end
    end

    // pick replica idx: above list first, then the ring start
    assign sel_al = idx_reg - ab_n_reg;
    always_comb
    begin
        sel_key = '0;
        for (int j = 0; j < REPLICAS; j++)
        begin
            if (idx_reg < ab_n_reg)
            begin
                if (NW'(j) == idx_reg)
                    sel_key = ab_key_reg[j];
            end
            else if (NW'(j) == sel_al)
                sel_key = al_key_reg[j];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chrs_pkg::BK_IDLE;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            rdv_reg       <= 1'b0;
            ab_n_reg      <= '0;
            al_n_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            rdv_reg       <= issue;
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                ab_n_reg <= '0;
                al_n_reg <= '0;
            end
            else if (rdv_reg)
            begin
                if (e_above && ab_n_reg != REP_N)
                    ab_n_reg <= ab_n_reg + 1'b1;
                if (al_n_reg != REP_N)
                    al_n_reg <= al_n_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        hash_reg     <= hash_next;
        idx_reg      <= idx_next;
        cnt_out_reg  <= cnt_out_next;
        out_key_reg  <= out_key_next;
        out_rank_reg <= out_rank_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg  <= out_ovf_next;
        out_last_reg <= out_last_next;
    end

    // command sequencing and result emission
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        addr_next      = addr_reg;
        hash_next      = hash_reg;
        idx_next       = idx_reg;
        cnt_out_next   = cnt_out_reg;
        out_valid_next = out_valid_reg && !pop;
        out_key_next   = out_key_reg;
        out_rank_next  = out_rank_reg;
        out_empty_next = out_empty_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        unique case (state_reg)
            chrs_pkg::BK_IDLE:
            begin
                if (q_valid && (q_cmd.op != chrs_pkg::OP_LOOKUP ||
                                count_reg != '0 || out_free))
                begin
                    q_pop = 1'b1;
                    unique case (q_cmd.op)
                        chrs_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            drop_next  = 1'b0;
                        end
                        chrs_pkg::OP_ADD:
                        begin
                            if (count_reg != CNT_MAX)
                                count_next = count_reg + 1'b1;
                            else
                                drop_next = 1'b1;
                        end
                        chrs_pkg::OP_LOOKUP:
                        begin
                            hash_next = q_cmd.data;
                            addr_next = '0;
                            idx_next  = '0;
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                out_key_next   = '0;
                                out_rank_next  = 2'd0;
                                out_empty_next = 1'b1;
                                out_ovf_next   = drop_reg;
                                out_last_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = chrs_pkg::BK_SCAN;
                                if (count_reg < CW'(REPLICAS))
                                    cnt_out_next = NW'(count_reg);
                                else
                                    cnt_out_next = REP_N;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            chrs_pkg::BK_SCAN:
            begin
                if (issue)
                    addr_next = addr_reg + 1'b1;
                else if (!rdv_reg)
                    state_next = chrs_pkg::BK_EMIT;
            end
            default:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_key_next   = sel_key;
                    out_rank_next  = 2'(idx_reg);
                    out_empty_next = 1'b0;
                    out_ovf_next   = drop_reg;
                    out_last_next  = (idx_reg + 1'b1 == cnt_out_reg);
                    idx_next       = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == cnt_out_reg)
                        state_next = chrs_pkg::BK_IDLE;
                end
            end
        endcase
    end

    // the table never holds more than its capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("node count above capacity");

    // an empty-table result is always the only one of its lookup
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_empty_reg) |-> out_last_reg)
        else $error("empty-table result not marked last");

    // a scan only runs over a non-empty table
    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == chrs_pkg::BK_SCAN) |-> (count_reg != '0))
        else $error("scan started on empty table");

    // no command is taken while a lookup is in progress
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != chrs_pkg::BK_IDLE) |-> !q_pop)
        else $error("command taken during lookup");

endmodule

`default_nettype wire

@@ rtl/consistent_hash_replica_select_top.sv @@
// consistent_hash_replica_select_top: top level of the replica selector
// instantiates chrs_front, chrs_cmd_queue and chrs_back; uses chrs_pkg
//
// usage:
//   requests enter through a queue-like port: a request is taken at a clock
//   edge with push high and full low. func 0 clears the node table, func 1
//   adds node_key, func 2 feeds one key byte (last_byte starts the lookup).
//   results leave through a queue-like port: while empty is low the oldest
//   result is on the result ports and it is taken when pop is high.
// timing:
//   key bytes are folded into the hash as they are taken, one after another
//   with no wait between. a node add keeps the front busy while the shared
//   32x32 multiplier forms two 64-bit products in three steps each. a lookup
//   scans the node table one entry per cycle through the memory read port,
//   then gives one result per cycle while the result port is not stalled, up to REPLICAS results.
//   a two-entry command queue lets the front keep hashing while the back
//   scans or waits on a stalled result port.
// reset:
//   the table is empty, the hash is at the fnv offset basis, no result
//   is pending. when pop stays low the result register holds and the back,
//   then the queue, then the front fill up and full rises.
`default_nettype none

module consistent_hash_replica_select_top #(
    parameter int MAX_NODES = 64,
    parameter int REPLICAS  = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  func,
    input  wire logic [63:0] node_key,
    input  wire logic [7:0]  key_byte,
    input  wire logic        byte_valid,
    input  wire logic        last_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      owner_key,
    output logic [1:0]       rank,
    output logic             table_empty,
    output logic             overflow,
    output logic             last
);

    logic           q_push;
    chrs_pkg::cmd_t q_wr_cmd;
    logic           q_full;
    logic           q_pop;
    chrs_pkg::cmd_t q_rd_cmd;
    logic           q_valid;

    // request front end
    chrs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .func       (func),
        .node_key   (node_key),
        .key_byte   (key_byte),
        .byte_valid (byte_valid),
        .last_byte  (last_byte),
        .q_push     (q_push),
        .q_cmd      (q_wr_cmd),
        .q_full     (q_full)
    );

    // decoupling queue
    chrs_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_cmd  (q_wr_cmd),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_cmd  (q_rd_cmd),
        .q_valid (q_valid)
    );

    // table and lookup back end
    chrs_back #(
        .MAX_NODES (MAX_NODES),
        .REPLICAS  (REPLICAS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (q_rd_cmd),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .owner_key   (owner_key),
        .rank        (rank),
        .table_empty (table_empty),
        .overflow    (overflow),
        .last        (last)
    );

endmodule

`default_nettype wire

@@ verif/chrs_ring_checker.sv @@
// chrs_ring_checker: watches the request and result ports of the replica selector,
// predicts ring lookups and compares them; depends on chrs_pkg
`default_nettype none

module chrs_ring_checker #(
    parameter int MAX_NODES = 64,
    parameter int REPLICAS  = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic        full,
    input  wire logic [1:0]  func,
    input  wire logic [63:0] node_key,
    input  wire logic [7:0]  key_byte,
    input  wire logic        byte_valid,
    input  wire logic        last_byte,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [63:0] owner_key,
    input  wire logic [1:0]  rank,
    input  wire logic        table_empty,
    input  wire logic        overflow,
    input  wire logic        last,
    output int               fail_count,
    output int               pending,
    output int               lookups_seen,
    output int               replicas_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] key;
        logic [1:0]  rnk;
        logic        tbl_empty;
        logic        ovf;
        logic        lst;
    } replica_t;

    replica_t    replica_q[$];
    logic [63:0] ring_keys[MAX_NODES];
    logic [63:0] ring_pos[MAX_NODES];
    int          node_cnt;
    logic [63:0] key_hash;
    logic        dropped;

    // splitmix64 placement of a node key on the ring
    function automatic logic [63:0] place_on_ring(logic [63:0] k);
        logic [63:0] v;
        v = k + chrs_pkg::MIX_GOLDEN;
        v = (v ^ (v >> 30)) * chrs_pkg::MIX_C1;
        v = (v ^ (v >> 27)) * chrs_pkg::MIX_C2;
        return v ^ (v >> 31);
    endfunction

    // queue the replicas that a lookup with hash h should produce
    task automatic predict_replicas(logic [63:0] h);
        int ord[MAX_NODES];
        int i, j, t, start, cnt;
        replica_t r;
        if (node_cnt == 0)
        begin
            r = '{key: 64'd0, rnk: 2'd0, tbl_empty: 1'b1, ovf: dropped, lst: 1'b1};
            replica_q.insert(replica_q.size(), r);
            return;
        end
        for (i = 0; i < node_cnt; i++)
            ord[i] = i;
        // insertion sort by (position, key)
        for (i = 1; i < node_cnt; i++)
        begin
            t = ord[i];
            j = i;
            while (j > 0 && (ring_pos[t] < ring_pos[ord[j-1]] ||
                   (ring_pos[t] == ring_pos[ord[j-1]] && ring_keys[t] < ring_keys[ord[j-1]])))
            begin
                ord[j] = ord[j-1];
                j--;
            end
            ord[j] = t;
        end
        start = 0;
        while (start < node_cnt && ring_pos[ord[start]] < h)
            start++;
        if (start == node_cnt)
            start = 0;
        cnt = node_cnt < REPLICAS ? node_cnt : REPLICAS;
        for (i = 0; i < cnt; i++)
        begin
            r.key       = ring_keys[ord[(start + i) % node_cnt]];
            r.rnk       = i[1:0];
            r.tbl_empty = 1'b0;
            r.ovf       = dropped;
            r.lst       = (i + 1 == cnt);
            replica_q.insert(replica_q.size(), r);
        end
    endtask

    // predictor on accepted requests, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin
        replica_t got, want;
        if (!rst_n)
        begin
            node_cnt      = 0;
            key_hash      = chrs_pkg::FNV_BASIS;
            dropped       = 1'b0;
            fail_count    = 0;
            lookups_seen  = 0;
            replicas_seen = 0;
            replica_q.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                got = '{key: owner_key, rnk: rank, tbl_empty: table_empty,
                        ovf: overflow, lst: last};
                replicas_seen++;
                if (replica_q.size() == 0)
                begin
                    $display("%0t: unexpected result key=%h rank=%0d", $time, owner_key, rank);
                    fail_count++;
                end
                else
                begin
                    want = replica_q.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected key=%h rank=%0d te=%b ovf=%b last=%b",
                                 $time, want.key, want.rnk, want.tbl_empty, want.ovf, want.lst);
                        $display("%0t:          actual   key=%h rank=%0d te=%b ovf=%b last=%b",
                                 $time, got.key, got.rnk, got.tbl_empty, got.ovf, got.lst);
                        fail_count++;
                    end
                end
            end
            if (push && !full)
            begin
                case (chrs_pkg::func_t'(func))
                    chrs_pkg::FN_CLEAR:
                    begin
                        node_cnt = 0;
                        dropped  = 1'b0;
                    end
                    chrs_pkg::FN_ADD:
                    begin
                        if (node_cnt < MAX_NODES)
                        begin
                            ring_keys[node_cnt] = node_key;
                            ring_pos[node_cnt]  = place_on_ring(node_key);
                            node_cnt++;
                        end
                        else
                            dropped = 1'b1;
                    end
                    chrs_pkg::FN_BYTE:
                    begin
                        if (byte_valid)
                            key_hash = (key_hash ^ {56'd0, key_byte}) * 64'h100000001B3;
                        if (last_byte)
                        begin
                            predict_replicas(key_hash);
                            key_hash = chrs_pkg::FNV_BASIS;
                            lookups_seen++;
                        end
                    end
                    default: ;
                endcase
            end
        end
        pending = replica_q.size();
    end
endmodule

`default_nettype wire

@@ verif/consistent_hash_replica_select_top_test.sv @@
// consistent_hash_replica_select_top_test: stimulus and verdict for the replica selector
// depends on chrs_pkg, consistent_hash_replica_select_top and chrs_ring_checker
`default_nettype none

module consistent_hash_replica_select_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [1:0]  func = chrs_pkg::FN_NONE;
    logic [63:0] node_key = '0;
    logic [7:0]  key_byte = '0;
    logic        byte_valid = 1'b0;
    logic        last_byte = 1'b0;
    logic        pop = 1'b0;
    logic        full, empty, table_empty, overflow, last;
    logic [63:0] owner_key;
    logic [1:0]  rank;
    int          fail_count, pending, lookups_seen, replicas_seen;
    int          cycles = 0;
    int          requests_sent = 0;
    int          stall_mode = 0;
    logic [63:0] node_pool[8];

    always #10 clk = ~clk;

    consistent_hash_replica_select_top u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .func(func),
        .node_key(node_key), .key_byte(key_byte), .byte_valid(byte_valid),
        .last_byte(last_byte), .empty(empty), .pop(pop), .owner_key(owner_key),
        .rank(rank), .table_empty(table_empty), .overflow(overflow), .last(last)
    );

    chrs_ring_checker u_checker (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .func(func),
        .node_key(node_key), .key_byte(key_byte), .byte_valid(byte_valid),
        .last_byte(last_byte), .empty(empty), .pop(pop), .owner_key(owner_key),
        .rank(rank), .table_empty(table_empty), .overflow(overflow), .last(last),
        .fail_count(fail_count), .pending(pending), .lookups_seen(lookups_seen),
        .replicas_seen(replicas_seen)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("consistent_hash_replica_select_top_test: FAIL");
            $finish;
        end
    end

    // result side stalls: phases of always-ready, random and heavy stall
    always @(posedge clk)
    begin
        if (cycles % 300 == 0)
            stall_mode <= int'($urandom_range(0, 2));
        case (stall_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            default: pop <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // present one request and hold it until taken, then maybe idle
    task automatic send_request(logic [1:0] f, logic [63:0] k, logic [7:0] b,
                                logic bv, logic lb);
        int gap;
        push       <= 1'b1;
        func       <= f;
        node_key   <= k;
        key_byte   <= b;
        byte_valid <= bv;
        last_byte  <= lb;
        @(posedge clk);
        while (full)
            @(posedge clk);
        requests_sent++;
        if ($urandom_range(0, 7) == 0)
        begin
            gap = int'($urandom_range(1, 6));
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_key(int len);
        int i;
        if (len == 0)
            send_request(chrs_pkg::FN_BYTE, 64'($urandom()), 8'($urandom()), 1'b0, 1'b1);
        for (i = 0; i < len; i++)
            send_request(chrs_pkg::FN_BYTE, {$urandom(), $urandom()}, 8'($urandom()),
                         ($urandom_range(0, 9) != 0) || i == len - 1, i == len - 1);
    endtask

    task automatic drain;
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        int i, n, r;
        logic [63:0] k;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, empty key, byte extremes
        send_key(0);
        send_request(chrs_pkg::FN_BYTE, '0, 8'h00, 1'b1, 1'b0);
        send_request(chrs_pkg::FN_BYTE, '1, 8'hFF, 1'b1, 1'b1);
        send_request(chrs_pkg::FN_NONE, '1, 8'hFF, 1'b1, 1'b1);
        send_request(chrs_pkg::FN_ADD, 64'd0, 8'h00, 1'b0, 1'b1);
        send_key(1);
        send_request(chrs_pkg::FN_ADD, '1, 8'hFF, 1'b1, 1'b0);
        send_request(chrs_pkg::FN_ADD, '1, 8'hFF, 1'b0, 1'b0);
        send_key(2);
        send_request(chrs_pkg::FN_ADD, 64'h5555_AAAA_5555_AAAA, 8'h00, 1'b0, 1'b0);
        send_key(3);
        send_request(chrs_pkg::FN_CLEAR, '1, 8'hFF, 1'b1, 1'b1);
        send_key(1);
        drain();

        // fill to capacity and past it for the overflow flag
        for (i = 0; i < 70; i++)
            send_request(chrs_pkg::FN_ADD, {$urandom(), $urandom()}, 8'($urandom()),
                         1'($urandom()), 1'($urandom()));
        send_key(2);
        send_key(0);
        drain();
        send_request(chrs_pkg::FN_CLEAR, 64'd0, 8'd0, 1'b0, 1'b0);

        // random phases of small rings
        while (requests_sent < 460)
        begin
            r = int'($urandom_range(0, 9));
            if (r == 0)
                send_request(chrs_pkg::FN_CLEAR, {$urandom(), $urandom()}, 8'($urandom()),
                             1'($urandom()), 1'($urandom()));
            else if (r == 1)
                send_request(chrs_pkg::FN_NONE, {$urandom(), $urandom()}, 8'($urandom()),
                             1'($urandom()), 1'($urandom()));
            else if (r < 5)
            begin
                n = int'($urandom_range(1, 3));
                for (i = 0; i < n; i++)
                begin
                    // reuse pool keys now and then for duplicates
                    k = ($urandom_range(0, 4) == 0) ? node_pool[3'($urandom_range(0, 7))]
                                                    : {$urandom(), $urandom()};
                    node_pool[3'($urandom_range(0, 7))] = k;
                    send_request(chrs_pkg::FN_ADD, k, 8'($urandom()), 1'($urandom()),
                                 1'($urandom()));
                end
            end
            else
                send_key(int'($urandom_range(0, 6)));
            if (requests_sent % 150 < 3)
                drain();
        end
        drain();
        repeat (50) @(posedge clk);

        $display("ran %0d requests, %0d lookups, %0d replica results checked",
                 requests_sent, lookups_seen, replicas_seen);
        if (fail_count == 0 && pending == 0)
            $display("consistent_hash_replica_select_top_test: PASS");
        else
            $display("consistent_hash_replica_select_top_test: FAIL");
        $finish;
    end

    // random words for node_pool start
    initial
        foreach (node_pool[j])
            node_pool[j] = {$urandom(), $urandom()};
endmodule

`default_nettype wire

@@ files.f @@
rtl/chrs_pkg.sv
rtl/chrs_front.sv
rtl/chrs_cmd_queue.sv
rtl/chrs_back.sv
rtl/consistent_hash_replica_select_top.sv
verif/chrs_ring_checker.sv
verif/consistent_hash_replica_select_top_test.sv
